// ===== rtl/mandelbrot_escape_time_pixel_unit_defines.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk and rst to be visible where it is used.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MBET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MBET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbet_pkg.sv =====
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared widths, register indexes, job type and colour tables for the
// escape-time pixel unit.
// ----------------------------------------------------------------------------
package mbet_pkg;

  localparam int PIXEL_W     = 10;
  localparam int COORD_W     = 32;
  localparam int ITER_W      = 12;
  localparam int COLOR_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_X_MIN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_X_STEP   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_MIN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER = 3'd4;

  localparam logic signed [COORD_W-1:0] X_MIN_RST  = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] X_STEP_RST = 32'sd786432;
  localparam logic signed [COORD_W-1:0] Y_MIN_RST  = -32'sd268435456;
  localparam logic signed [COORD_W-1:0] Y_STEP_RST = 32'sd524288;
  localparam logic [ITER_W-1:0]         MAX_ITER_RST = 12'd100;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // one point handed from the mapper to the iteration engine
  typedef struct packed {
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;
    logic [ITER_W-1:0]         max_iter;
  } job_t;

  localparam int TABLE_LEN   = 50;
  localparam int TABLE_IDX_W = 6;

  // 127*(1+sin(2*pi*n/50)) and 127*(1+cos(2*pi*n/50)), truncated
  localparam logic [COLOR_W-1:0] SIN_TAB [TABLE_LEN] = '{
    8'd127, 8'd142, 8'd158, 8'd173, 8'd188, 8'd201, 8'd213, 8'd224, 8'd234, 8'd241,
    8'd247, 8'd251, 8'd253, 8'd253, 8'd251, 8'd247, 8'd241, 8'd234, 8'd224, 8'd213,
    8'd201, 8'd188, 8'd173, 8'd158, 8'd142, 8'd127, 8'd111, 8'd95,  8'd80,  8'd65,
    8'd52,  8'd40,  8'd29,  8'd19,  8'd12,  8'd6,   8'd2,   8'd0,   8'd0,   8'd2,
    8'd6,   8'd12,  8'd19,  8'd29,  8'd40,  8'd52,  8'd65,  8'd80,  8'd95,  8'd111
  };

  localparam logic [COLOR_W-1:0] COS_TAB [TABLE_LEN] = '{
    8'd254, 8'd252, 8'd250, 8'd245, 8'd238, 8'd229, 8'd219, 8'd207, 8'd195, 8'd181,
    8'd166, 8'd150, 8'd134, 8'd119, 8'd103, 8'd87,  8'd72,  8'd58,  8'd46,  8'd34,
    8'd24,  8'd15,  8'd8,   8'd3,   8'd1,   8'd0,   8'd1,   8'd3,   8'd8,   8'd15,
    8'd24,  8'd34,  8'd46,  8'd58,  8'd72,  8'd87,  8'd103, 8'd119, 8'd134, 8'd150,
    8'd166, 8'd181, 8'd195, 8'd207, 8'd219, 8'd229, 8'd238, 8'd245, 8'd250, 8'd252
  };

  // fold an 8-bit phase count into the table range
  function automatic logic [TABLE_IDX_W-1:0] table_index(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      if (r >= 8'(TABLE_LEN)) begin
        r = r - 8'(TABLE_LEN);
      end
    end
    return r[TABLE_IDX_W-1:0];
  endfunction

  // advance a table index by half a period
  function automatic logic [TABLE_IDX_W-1:0] half_turn(input logic [TABLE_IDX_W-1:0] idx);
    logic [TABLE_IDX_W:0] s;
    s = {1'b0, idx} + (TABLE_IDX_W+1)'(TABLE_LEN / 2);
    if (s >= (TABLE_IDX_W+1)'(TABLE_LEN)) begin
      s = s - (TABLE_IDX_W+1)'(TABLE_LEN);
    end
    return s[TABLE_IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/mbet_if.sv =====
// ----------------------------------------------------------------------------
// mbet_if
// Valid/ready channels of the escape-time pixel unit: pixel in, result out
// and register writes.
// ----------------------------------------------------------------------------
interface mbet_pixel_if import mbet_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_x;
  logic [PIXEL_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mbet_result_if import mbet_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ITER_W-1:0]  escape_count;
  logic               inside_set;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output escape_count, output inside_set,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input escape_count, input inside_set,
                  input red, input green, input blue, output ready);
endinterface

interface mbet_cfg_if import mbet_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mandelbrot_escape_time_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit: escape-time pixel engine with colour map
// A pixel passes the mapper register, the queue, the iteration loop and the
// output register. Points are iterated one at a time, with a multiply state and
// an update state per step, and the result register stalls on the receiver.
// Reset: synchronous rst empties the queue and pipeline, loads default view.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_unit import mbet_pkg::*; #(
  parameter int FRACTION_BITS = 28,
  parameter int COLOR_PERIOD  = 50
) (
  input  logic          clk,
  input  logic          rst,
  mbet_pixel_if.sink    pixel,
  mbet_result_if.source result,
  mbet_cfg_if.sink      cfg
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  mbet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  mbet_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  mbet_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .COLOR_PERIOD  (COLOR_PERIOD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .result    (result)
  );

endmodule

// ===== rtl/mbet_queue.sv =====
// ----------------------------------------------------------------------------
// mbet_queue
// Short FIFO of mapped points between the mapper and the iteration engine.
// ----------------------------------------------------------------------------
module mbet_queue import mbet_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (fill != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= QUEUE_PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= QUEUE_PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        fill <= (QUEUE_PTR_W+1)'(fill + 1'b1);
      end else if (do_pop && !do_push) begin
        fill <= (QUEUE_PTR_W+1)'(fill - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/mbet_front.sv =====
// ----------------------------------------------------------------------------
// mbet_front
// Holds the view registers, accepts pixels and maps each one to a point c,
// saturated to Q4.28, pushing it with the iteration limit into the queue.
// ----------------------------------------------------------------------------
module mbet_front import mbet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mbet_pixel_if.sink  pixel,
  mbet_cfg_if.sink    cfg,
  output logic        push_valid,
  input  logic        push_ready,
  output job_t        push_job
);

  localparam int PROD_W = COORD_W + PIXEL_W + 1;

  logic signed [COORD_W-1:0] x_min;
  logic signed [COORD_W-1:0] x_step;
  logic signed [COORD_W-1:0] y_min;
  logic signed [COORD_W-1:0] y_step;
  logic [ITER_W-1:0]         max_iter;

  logic                      s1_valid;
  logic signed [PROD_W-1:0]  prod_re;
  logic signed [PROD_W-1:0]  prod_im;

  // exact base + offset, clamped to the coordinate range
  function automatic logic signed [COORD_W-1:0] map_sat(
    input logic signed [COORD_W-1:0] base,
    input logic signed [PROD_W-1:0]  offset
  );
    logic signed [PROD_W:0] sum;
    sum = (PROD_W+1)'(base) + (PROD_W+1)'(offset);
    if (sum[PROD_W:COORD_W-1] == {(PROD_W-COORD_W+2){sum[COORD_W-1]}}) begin
      return sum[COORD_W-1:0];
    end else if (sum[PROD_W]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min    <= X_MIN_RST;
      x_step   <= X_STEP_RST;
      y_min    <= Y_MIN_RST;
      y_step   <= Y_STEP_RST;
      max_iter <= MAX_ITER_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_X_MIN:    x_min    <= cfg.data;
        REG_X_STEP:   x_step   <= cfg.data;
        REG_Y_MIN:    y_min    <= cfg.data;
        REG_Y_STEP:   y_step   <= cfg.data;
        REG_MAX_ITER: max_iter <= cfg.data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1 holds the products until the queue takes the beat
  assign pixel.ready = !s1_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      prod_re <= $signed({1'b0, pixel.pixel_x}) * x_step;
      prod_im <= $signed({1'b0, pixel.pixel_y}) * y_step;
    end
  end

  assign push_valid        = s1_valid;
  assign push_job.c_re     = map_sat(x_min, prod_re);
  assign push_job.c_im     = map_sat(y_min, prod_im);
  assign push_job.max_iter = max_iter;

endmodule

// ===== rtl/mbet_back.sv =====
// ----------------------------------------------------------------------------
// mbet_back
// Iteration engine: runs z = z*z + c over a multiply state and an update
// state, then colours the point and holds the result in an output register.
// ----------------------------------------------------------------------------
module mbet_back import mbet_pkg::*; #(
  parameter int FRACTION_BITS = 28,
  parameter int COLOR_PERIOD  = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  job_t          pop_job,
  mbet_result_if.source result
);

  localparam int MUL_W = 2 * COORD_W;
  localparam int ACC_W = MUL_W + 2;
  localparam int MOD_W = $clog2(COLOR_PERIOD);
  localparam logic [MUL_W:0] LIMIT = (MUL_W+1)'(4) << FRACTION_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                state;
  logic signed [COORD_W-1:0] re;
  logic signed [COORD_W-1:0] im;
  logic signed [COORD_W-1:0] c_re;
  logic signed [COORD_W-1:0] c_im;
  logic [ITER_W-1:0]         lim;
  logic [ITER_W-1:0]         count;
  logic [MOD_W-1:0]          phase;
  logic [MUL_W-1:0]          prod_rr;
  logic [MUL_W-1:0]          prod_ii;
  logic signed [MUL_W-1:0]   prod_ri;

  logic                      out_valid;
  logic [ITER_W-1:0]         out_count;
  logic                      out_inside;
  logic [COLOR_W-1:0]        out_red;
  logic [COLOR_W-1:0]        out_green;
  logic [COLOR_W-1:0]        out_blue;

  logic [MUL_W-1:0]          sq_rr;
  logic [MUL_W-1:0]          sq_ii;
  logic [MUL_W:0]            mag;
  logic                      over_limit;
  logic signed [ACC_W-1:0]   n_re;
  logic signed [ACC_W-1:0]   n_im;
  logic                      fits;
  logic                      load_job;
  logic                      mul_go;
  logic                      upd_step;
  logic                      done_load;
  logic                      in_set;
  logic [TABLE_IDX_W-1:0]    idx;

  assign sq_rr      = prod_rr >> FRACTION_BITS;
  assign sq_ii      = prod_ii >> FRACTION_BITS;
  assign mag        = {1'b0, sq_rr} + {1'b0, sq_ii};
  assign over_limit = (mag > LIMIT);
  assign n_re       = $signed({2'b00, sq_rr}) - $signed({2'b00, sq_ii}) + ACC_W'(c_re);
  assign n_im       = ACC_W'(prod_ri >>> (FRACTION_BITS - 1)) + ACC_W'(c_im);
  assign fits       = (n_re[ACC_W-1:COORD_W-1] == {(ACC_W-COORD_W+1){n_re[COORD_W-1]}})
                   && (n_im[ACC_W-1:COORD_W-1] == {(ACC_W-COORD_W+1){n_im[COORD_W-1]}});

  assign pop_ready = (state == ST_IDLE);
  assign load_job  = pop_valid && (state == ST_IDLE);
  assign mul_go    = (state == ST_MUL) && (count < lim);
  assign upd_step  = (state == ST_UPD) && !over_limit;
  assign done_load = (state == ST_DONE) && (!out_valid || result.ready);

  assign in_set = (count >= lim);
  assign idx    = table_index(8'(phase));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= mul_go ? ST_UPD : ST_DONE;
        end
        ST_UPD: begin
          state <= (upd_step && fits) ? ST_MUL : ST_DONE;
        end
        ST_DONE: begin
          if (done_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the first update always gives z = c, so it is made at load
  always_ff @(posedge clk) begin
    if (load_job) begin
      c_re  <= pop_job.c_re;
      c_im  <= pop_job.c_im;
      re    <= pop_job.c_re;
      im    <= pop_job.c_im;
      lim   <= pop_job.max_iter;
      count <= '0;
      phase <= '0;
    end
    if (mul_go) begin
      prod_rr <= re * re;
      prod_ii <= im * im;
      prod_ri <= re * im;
    end
    if (upd_step) begin
      count <= ITER_W'(count + 1'b1);
      phase <= (phase == MOD_W'(COLOR_PERIOD - 1)) ? '0 : MOD_W'(phase + 1'b1);
      if (fits) begin
        re <= n_re[COORD_W-1:0];
        im <= n_im[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_count  <= count;
      out_inside <= in_set;
      out_red    <= in_set ? '0 : SIN_TAB[idx];
      out_green  <= in_set ? '0 : COS_TAB[idx];
      out_blue   <= in_set ? '0 : SIN_TAB[half_turn(idx)];
    end
  end

  assign result.valid        = out_valid;
  assign result.escape_count = out_count;
  assign result.inside_set   = out_inside;
  assign result.red          = out_red;
  assign result.green        = out_green;
  assign result.blue         = out_blue;

endmodule

// ===== rtl/mbet_checker.sv =====
// ----------------------------------------------------------------------------
// mbet_checker
// Port-level checks of the escape-time pixel unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_unit_defines.svh"

module mbet_checker import mbet_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [ITER_W-1:0]      escape_count,
  input logic                   inside_set,
  input logic [COLOR_W-1:0]     red,
  input logic [COLOR_W-1:0]     green,
  input logic [COLOR_W-1:0]     blue,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ITER_W-1:0] lim_shadow;
  logic [3:0]        outstanding;
  logic              in_beat;
  logic              out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // track the iteration limit as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      lim_shadow <= MAX_ITER_RST;
    end else if (cfg_valid && cfg_ready && (cfg_index == REG_MAX_ITER)) begin
      lim_shadow <= cfg_data[ITER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_beat && !out_beat) begin
      outstanding <= 4'(outstanding + 1'b1);
    end else if (out_beat && !in_beat) begin
      outstanding <= 4'(outstanding - 1'b1);
    end
  end

  `MBET_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(escape_count) && $stable(inside_set) && $stable(red) && $stable(green) && $stable(blue), "result beat changed while stalled")
  `MBET_ASSERT_NOW(a_inside_black, out_valid && inside_set, red == '0 && green == '0 && blue == '0, "point inside the set is not black")
  `MBET_ASSERT_NOW(a_count_limit, out_valid, escape_count <= lim_shadow && inside_set == (escape_count == lim_shadow), "escape count disagrees with the iteration limit")
  `MBET_ASSERT_NOW(a_no_extra_beat, out_beat, outstanding != '0, "result beat without a pixel beat")

endmodule

bind mandelbrot_escape_time_pixel_unit mbet_checker u_mbet_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (pixel.valid),
  .in_ready     (pixel.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .escape_count (result.escape_count),
  .inside_set   (result.inside_set),
  .red          (result.red),
  .green        (result.green),
  .blue         (result.blue),
  .cfg_valid    (cfg.valid),
  .cfg_ready    (cfg.ready),
  .cfg_index    (cfg.index),
  .cfg_data     (cfg.data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: escape-time pixel unit testbench
// Drives pixel beats on a valid/ready channel and writes the view registers
// between phases. Each accepted pixel is shaded by the table or an in-bench
// fixed-point iteration; results are compared field by field, in order.
// A short directed table comes first, then phases of random pixels over
// random views, one of them with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import mbet_pkg::*;

  localparam int     FRAC          = 28;
  localparam int     COLOR_PERIOD  = 50;
  localparam longint COORD_MAX     = 64'sd2147483647;
  localparam longint COORD_MIN     = -64'sd2147483648;
  localparam longint ESCAPE_RADIUS = 64'sd4 <<< FRAC;
  localparam int     STALL_CYCLES  = 800;
  // covers the worst item at the largest limit, plus the long hold-off
  localparam int     WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] x_step;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] y_step;
    logic [ITER_W-1:0]         max_iter;
  } view_t;

  typedef struct packed {
    logic [ITER_W-1:0]  escape_count;
    logic               inside_set;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } shade_t;

  typedef struct packed {
    view_t              v;
    logic [PIXEL_W-1:0] px;
    logic [PIXEL_W-1:0] py;
    logic               typed;
    shade_t             res;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst;

  mbet_pixel_if  pixel_ch ();
  mbet_result_if result_ch ();
  mbet_cfg_if    cfg_ch ();

  mandelbrot_escape_time_pixel_unit dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  view_t      view;
  shade_t     awaited_shades [$];
  pixel_row_t pixel_table [$];
  int         mismatches = 0;
  bit         calm = 1'b0;
  int         stall_asked = 0;

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // escape-time iteration and colour lookup under the current view
  function automatic shade_t shade_pixel(input logic [PIXEL_W-1:0] px,
                                         input logic [PIXEL_W-1:0] py);
    longint c_re, c_im, re, im, sq_re, sq_im, n_re, n_im, count, limit;
    bit     escaped;
    int     idx;
    shade_t s;
    c_re = clamp_coord(longint'(view.x_min) + longint'(px) * longint'(view.x_step));
    c_im = clamp_coord(longint'(view.y_min) + longint'(py) * longint'(view.y_step));
    limit = longint'(view.max_iter);
    re = 0;
    im = 0;
    count = -1;
    escaped = 1'b0;
    while (count < limit && !escaped) begin
      sq_re = (re * re) >>> FRAC;
      sq_im = (im * im) >>> FRAC;
      if (sq_re + sq_im > ESCAPE_RADIUS) break;
      n_re = sq_re - sq_im + c_re;
      n_im = ((re * im) >>> (FRAC - 1)) + c_im;
      count++;
      // an overflowing update still counts, then the point is out
      if (n_re > COORD_MAX || n_re < COORD_MIN || n_im > COORD_MAX || n_im < COORD_MIN) begin
        escaped = 1'b1;
      end else begin
        re = n_re;
        im = n_im;
      end
    end
    s = '0;
    s.escape_count = count[ITER_W-1:0];
    s.inside_set = (count >= limit);
    if (!s.inside_set) begin
      idx = int'(count % COLOR_PERIOD) % TABLE_LEN;
      s.red = SIN_TAB[idx];
      s.green = COS_TAB[idx];
      s.blue = SIN_TAB[(idx + TABLE_LEN / 2) % TABLE_LEN];
    end
    return s;
  endfunction

  function automatic view_t make_view(input logic [31:0] xm, input logic [31:0] xs,
                                      input logic [31:0] ym, input logic [31:0] ys,
                                      input logic [ITER_W-1:0] mi);
    view_t v;
    v.x_min = xm;
    v.x_step = xs;
    v.y_min = ym;
    v.y_step = ys;
    v.max_iter = mi;
    return v;
  endfunction

  function automatic view_t random_view();
    view_t v;
    v.x_min = $urandom_range(0, 939524096) - 671088640;   // -2.5 .. 1.0
    v.y_min = $urandom_range(0, 805306368) - 402653184;   // -1.5 .. 1.5
    v.x_step = $urandom_range(1, 1 << $urandom_range(6, 20));
    v.y_step = $urandom_range(1, 1 << $urandom_range(6, 20));
    if ($urandom_range(0, 3) == 0) v.x_step = -v.x_step;
    if ($urandom_range(0, 3) == 0) v.y_step = -v.y_step;
    v.max_iter = ($urandom_range(0, 7) == 0) ? ITER_W'($urandom_range(0, 15))
                                             : ITER_W'($urandom_range(16, 255));
    return v;
  endfunction

  task automatic add_row(input view_t v, input logic [PIXEL_W-1:0] px,
                         input logic [PIXEL_W-1:0] py, input bit typed,
                         input logic [ITER_W-1:0] cnt, input logic ins,
                         input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                         input logic [COLOR_W-1:0] b);
    pixel_row_t row;
    row.v = v;
    row.px = px;
    row.py = py;
    row.typed = typed;
    row.res = '{escape_count: cnt, inside_set: ins, red: r, green: g, blue: b};
    pixel_table.push_back(row);
  endtask

  // call at a falling edge; returns at the falling edge after the beat
  task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic [PIXEL_W-1:0] py,
                            input bit typed, input shade_t typed_res);
    while (!calm && $urandom_range(0, 99) < 24) begin
      pixel_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.pixel_x <= px;
    pixel_ch.pixel_y <= py;
    do @(posedge clk); while (!pixel_ch.ready);
    awaited_shades.push_back(typed ? typed_res : shade_pixel(px, py));
    @(negedge clk);
  endtask

  task automatic drain();
    pixel_ch.valid <= 1'b0;
    while (awaited_shades.size() != 0) @(negedge clk);
  endtask

  // leaves valid high; the caller lowers it once the writes are done
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      REG_X_MIN:    view.x_min = data;
      REG_X_STEP:   view.x_step = data;
      REG_Y_MIN:    view.y_min = data;
      REG_Y_STEP:   view.y_step = data;
      REG_MAX_ITER: view.max_iter = data[ITER_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_view(input view_t want);
    drain();
    if (want.x_min != view.x_min) write_register(REG_X_MIN, want.x_min);
    if (want.x_step != view.x_step) write_register(REG_X_STEP, want.x_step);
    if (want.y_min != view.y_min) write_register(REG_Y_MIN, want.y_min);
    if (want.y_step != view.y_step) write_register(REG_Y_STEP, want.y_step);
    if (want.max_iter != view.max_iter) write_register(REG_MAX_ITER, 32'(want.max_iter));
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random back-pressure plus the requested long hold-off
  initial begin
    int stall_served;
    int hold_left;
    stall_served = 0;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asked != stall_served) begin
        stall_served = stall_asked;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  always @(posedge clk) begin
    shade_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_shades.size() == 0) begin
        $error("result beat with no pixel outstanding");
        mismatches++;
      end else begin
        want = awaited_shades.pop_front();
        if (result_ch.escape_count !== want.escape_count) begin
          $error("escape_count: expected %0d, got %0d", want.escape_count,
                 result_ch.escape_count);
          mismatches++;
        end
        if (result_ch.inside_set !== want.inside_set) begin
          $error("inside_set: expected %0d, got %0d", want.inside_set, result_ch.inside_set);
          mismatches++;
        end
        if (result_ch.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, result_ch.red);
          mismatches++;
        end
        if (result_ch.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, result_ch.green);
          mismatches++;
        end
        if (result_ch.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, result_ch.blue);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    int quiet;
    if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL mandelbrot_escape_time_pixel_unit");
        $finish;
      end
    end
  end

  initial begin
    view_t      dflt, minus2, plus2, zero, top, bottom, want;
    pixel_row_t row;
    rst = 1'b1;
    pixel_ch.valid = 1'b0;
    pixel_ch.pixel_x = '0;
    pixel_ch.pixel_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;

    dflt = make_view(X_MIN_RST, X_STEP_RST, Y_MIN_RST, Y_STEP_RST, MAX_ITER_RST);
    view = dflt;
    minus2 = make_view(32'hE000_0000, 0, 0, 0, 100);
    plus2 = make_view(32'h2000_0000, 0, 0, 0, 100);
    zero = make_view(0, 0, 0, 0, 1);
    top = make_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    bottom = make_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);

    // default view: the corner point escapes on the first test
    add_row(dflt, 0, 0, 1, 0, 0, 127, 254, 127);
    add_row(dflt, 1023, 1023, 0, 0, 0, 0, 0, 0);
    add_row(dflt, 1023, 0, 0, 0, 0, 0, 0, 0);
    add_row(dflt, 0, 1023, 0, 0, 0, 0, 0, 0);
    add_row(dflt, 682, 512, 0, 0, 0, 0, 0, 0);
    add_row(dflt, 511, 300, 0, 0, 0, 0, 0, 0);
    // |z|^2 sits exactly on 4 at c = -2 and never leaves
    add_row(minus2, 5, 7, 1, 100, 1, 0, 0, 0);
    add_row(plus2, 1023, 1023, 1, 1, 0, 142, 252, 111);
    // zero limit still makes one update
    plus2.max_iter = 0;
    add_row(plus2, 1023, 1023, 1, 0, 1, 0, 0, 0);
    add_row(zero, 0, 0, 1, 1, 1, 0, 0, 0);
    zero.max_iter = 12'hFFF;
    add_row(zero, 1023, 1023, 1, 4095, 1, 0, 0, 0);
    // mapping saturates at both ends of the coordinate range
    add_row(top, 1023, 1023, 1, 0, 0, 127, 254, 127);
    add_row(top, 0, 0, 1, 0, 0, 127, 254, 127);
    add_row(bottom, 1023, 1023, 1, 0, 0, 127, 254, 127);
    add_row(bottom, 0, 0, 1, 0, 0, 127, 254, 127);
    add_row(make_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1),
            1023, 1023, 0, 0, 0, 0, 0, 0);
    add_row(make_view(32'h1000_0000, -32'sd786432, 32'h1000_0000, -32'sd524288, 100),
            1023, 1023, 0, 0, 0, 0, 0, 0);
    add_row(make_view(32'h1000_0000, -32'sd786432, 32'h1000_0000, -32'sd524288, 100),
            0, 0, 0, 0, 0, 0, 0, 0);
    // just right of the cusp: slow escape, colour index wraps
    add_row(make_view(32'd67135660, 0, 0, 0, 12'hFFF), 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(make_view(32'd67135660, 32'd65536, 0, 32'd65536, 12'hFFF), 1023, 1023, 0,
            0, 0, 0, 0, 0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (pixel_table[i]) begin
      row = pixel_table[i];
      if (row.v != view) apply_view(row.v);
      send_pixel(row.px, row.py, row.typed, row.res);
    end

    for (int phase = 0; phase < 12; phase++) begin
      want = random_view();
      if (phase == 0) want = dflt;
      if (phase == 3) begin
        want = make_view($urandom(), $urandom(), $urandom(), $urandom(),
                         ITER_W'($urandom_range(0, 300)));
      end
      if (phase == 5) want.max_iter = ITER_W'($urandom_range(4, 20));
      if (phase == 9) want.max_iter = 12'hFFF;
      apply_view(want);
      calm = (phase == 7);
      // hold the result side off so the unit backs up into the pixel channel
      if (phase == 5) stall_asked++;
      repeat ((phase == 9) ? 6 : 105) begin
        send_pixel(PIXEL_W'($urandom_range(0, 1023)), PIXEL_W'($urandom_range(0, 1023)),
                   1'b0, '0);
      end
    end
    calm = 1'b0;

    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS mandelbrot_escape_time_pixel_unit");
    end else begin
      $display("FAIL mandelbrot_escape_time_pixel_unit");
    end
    $finish;
  end

endmodule
